// ===== src/cassette_pulse_width_byte_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the cassette pulse width byte decoder
// ----------------------------------------------------------------------------
`ifndef CASSETTE_PULSE_WIDTH_BYTE_DECODER_CORE_ASSERT_SVH
`define CASSETTE_PULSE_WIDTH_BYTE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPWBD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("cpwbd same-cycle check failed");

// next-cycle implication, checked out of reset
`define CPWBD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("cpwbd next-cycle check failed");

`endif

// ===== src/cpwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpwbd_pkg
// shared types and constants of the cassette pulse width byte decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpwbd_pkg;

    localparam logic [7:0] SYNC_MARK  = 8'hA5;
    localparam logic [7:0] QUOTE_CHAR = 8'h22;

    localparam int NAME_CNT_W = 5;
    localparam int RUN_W      = 8;

    typedef enum logic [1:0] {
        CFG_LEVEL_THRESHOLD = 2'd0,
        CFG_SPEED_SELECT    = 2'd1,
        CFG_SKIP_NAME       = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_NAME_SYNC = 2'd1,
        STATUS_BAD_NAME     = 2'd2,
        STATUS_NO_PROG_SYNC = 2'd3
    } status_t;

    typedef struct packed {
        logic valid;
        logic value;
    } bit_t;

    typedef struct packed {
        logic       produce;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       in_program;
        logic       done;
        status_t    status;
    } result_t;

    // minimum low run for a one bit, per tape speed
    function automatic logic [4:0] one_width(input logic [2:0] speed);
        logic [4:0] w;
        case (speed)
            3'd0:    w = 5'd17;
            3'd1:    w = 5'd15;
            3'd2:    w = 5'd13;
            3'd3:    w = 5'd12;
            3'd4:    w = 5'd10;
            default: w = 5'd8;
        endcase
        return w;
    endfunction

endpackage

// ===== src/cpwbd_bit_slicer.sv =====
// ----------------------------------------------------------------------------
// cpwbd_bit_slicer
// measures low runs of tape samples and turns each finished run into a bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpwbd_bit_slicer
    import cpwbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       sample,
    input  logic             last_sample,
    input  logic [7:0]       level_threshold,
    input  logic [2:0]       speed_select,
    output bit_t             bit_out
);

    logic             in_low_reg;
    logic             in_low_next;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic             is_low;

    assign is_low = (sample <= level_threshold);

    always_comb
    begin
        bit_out.valid = !is_low && in_low_reg;
        bit_out.value = (run_reg >= {3'd0, one_width(speed_select)});
    end

    always_comb
    begin
        in_low_next = in_low_reg;
        run_next    = run_reg;
        if (last_sample)
        begin
            in_low_next = 1'b0;
            run_next    = '0;
        end
        else if (is_low)
        begin
            in_low_next = 1'b1;
            if (!in_low_reg)
                run_next = RUN_W'(1);
            else if (run_reg != '1)
                run_next = run_reg + RUN_W'(1);
        end
        else
        begin
            in_low_next = 1'b0;
            run_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg <= 1'b0;
            run_reg    <= '0;
        end
        else if (advance)
        begin
            in_low_reg <= in_low_next;
            run_reg    <= run_next;
        end
    end

endmodule

// ===== src/cpwbd_byte_framer.sv =====
// ----------------------------------------------------------------------------
// cpwbd_byte_framer
// sync hunt, byte assembly and name/program sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpwbd_byte_framer
    import cpwbd_pkg::*;
#(
    parameter int NAME_MAX_BYTES = 30
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    last_sample,
    input  logic    skip_name,
    input  bit_t    bit_in,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_HUNT_FIRST,
        ST_NAME,
        ST_HUNT_PROG,
        ST_PROG,
        ST_FAILED
    } stage_t;

    localparam logic [NAME_CNT_W-1:0] NameMax = NAME_CNT_W'(NAME_MAX_BYTES);

    stage_t                stage_reg;
    stage_t                stage_next;
    logic [7:0]            window_reg;
    logic [7:0]            window_next;
    logic [3:0]            count_reg;
    logic [3:0]            count_next;
    logic [NAME_CNT_W-1:0] name_cnt_reg;
    logic [NAME_CNT_W-1:0] name_cnt_next;
    logic [7:0]            shifted;
    logic                  got;
    status_t               status_c;

    assign shifted = {window_reg[6:0], bit_in.value};

    always_comb
    begin
        stage_next    = stage_reg;
        window_next   = window_reg;
        count_next    = count_reg;
        name_cnt_next = name_cnt_reg;
        got           = 1'b0;
        if (bit_in.valid)
        begin
            window_next = shifted;
            case (stage_reg)
                ST_HUNT_FIRST, ST_HUNT_PROG:
                begin
                    if (shifted == SYNC_MARK)
                    begin
                        stage_next  = (stage_reg == ST_HUNT_FIRST && !skip_name)
                                      ? ST_NAME : ST_PROG;
                        window_next = '0;
                        count_next  = '0;
                    end
                end
                ST_NAME, ST_PROG:
                begin
                    if (count_reg == 4'd7)
                    begin
                        got         = 1'b1;
                        window_next = '0;
                        count_next  = '0;
                        if (stage_reg == ST_NAME)
                        begin
                            name_cnt_next = name_cnt_reg + NAME_CNT_W'(1);
                            if (name_cnt_next >= NameMax)
                                stage_next = ST_FAILED;
                            else if (name_cnt_next >= NAME_CNT_W'(2)
                                     && shifted == QUOTE_CHAR)
                                stage_next = ST_HUNT_PROG;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end
                default:
                begin
                    window_next = shifted;
                end
            endcase
        end
    end

    always_comb
    begin
        case (stage_next)
            ST_HUNT_FIRST: status_c = skip_name ? STATUS_NO_PROG_SYNC : STATUS_NO_NAME_SYNC;
            ST_NAME:       status_c = STATUS_BAD_NAME;
            ST_FAILED:     status_c = STATUS_BAD_NAME;
            ST_HUNT_PROG:  status_c = STATUS_NO_PROG_SYNC;
            default:       status_c = STATUS_OK;
        endcase
    end

    always_comb
    begin
        result.produce    = got || last_sample;
        result.byte_valid = got;
        result.data_byte  = got ? shifted : 8'd0;
        result.in_program = got && (stage_reg == ST_PROG);
        result.done       = last_sample;
        result.status     = last_sample ? status_c : STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= ST_HUNT_FIRST;
            window_reg   <= '0;
            count_reg    <= '0;
            name_cnt_reg <= '0;
        end
        else if (advance)
        begin
            if (last_sample)
            begin
                stage_reg    <= ST_HUNT_FIRST;
                window_reg   <= '0;
                count_reg    <= '0;
                name_cnt_reg <= '0;
            end
            else
            begin
                stage_reg    <= stage_next;
                window_reg   <= window_next;
                count_reg    <= count_next;
                name_cnt_reg <= name_cnt_next;
            end
        end
    end

endmodule

// ===== src/cassette_pulse_width_byte_decoder_core.sv =====
// ----------------------------------------------------------------------------
// cassette_pulse_width_byte_decoder_core
// pulse width tape decoder: samples in, sync-framed name/program bytes out
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  in        in_valid, in_stall, sample, last_sample    request in
//  out       out_valid, out_stall, byte_valid,          request out
//            data_byte, in_program, done_res, status
//  cfg       cfg_we, cfg_index, cfg_data                write only
//
//  one sample per cycle sustained unless in_stall is raised; input register,
//  then decode logic into the result register
//  reset clears all decode state, thresholds return to defaults
//  in_stall rises only while a held result is stalled and the queued
//  sample produces a result of its own
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cassette_pulse_width_byte_decoder_core_assert.svh"

module cassette_pulse_width_byte_decoder_core
    import cpwbd_pkg::*;
#(
    parameter int NAME_MAX_BYTES = 30
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] sample,
    input  logic       last_sample,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] data_byte,
    output logic       in_program,
    output logic       done_res,
    output logic [1:0] status,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] level_threshold_reg;
    logic [2:0] speed_select_reg;
    logic       skip_name_reg;

    logic       in_vld_reg;
    logic [7:0] sample_reg;
    logic       last_reg;
    logic       advance;
    logic       in_accept;

    logic       out_vld_reg;
    result_t    res_reg;
    result_t    res_c;
    bit_t       bit_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_threshold_reg <= 8'd128;
            speed_select_reg    <= 3'd0;
            skip_name_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data;
                CFG_SPEED_SELECT:    speed_select_reg    <= cfg_data[2:0];
                CFG_SKIP_NAME:       skip_name_reg       <= cfg_data[0];
                default:             level_threshold_reg <= level_threshold_reg;
            endcase
        end
    end

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall || !res_c.produce);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_accept)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
        end
    end

    cpwbd_bit_slicer u_slicer (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .sample          (sample_reg),
        .last_sample     (last_reg),
        .level_threshold (level_threshold_reg),
        .speed_select    (speed_select_reg),
        .bit_out         (bit_c)
    );

    cpwbd_byte_framer #(
        .NAME_MAX_BYTES (NAME_MAX_BYTES)
    ) u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .last_sample (last_reg),
        .skip_name   (skip_name_reg),
        .bit_in      (bit_c),
        .result      (res_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && res_c.produce)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_c.produce)
            res_reg <= res_c;
    end

    assign out_valid  = out_vld_reg;
    assign byte_valid = res_reg.byte_valid;
    assign data_byte  = res_reg.data_byte;
    assign in_program = res_reg.in_program;
    assign done_res   = res_reg.done;
    assign status     = res_reg.status;

    `CPWBD_ASSERT_IMP(a_result_not_empty, clk, rst_n, out_valid, byte_valid || done_res)
    `CPWBD_ASSERT_IMP(a_status_only_at_end, clk, rst_n, out_valid && !done_res,
                      status == STATUS_OK)
    `CPWBD_ASSERT_IMP(a_no_byte_clean, clk, rst_n, out_valid && !byte_valid,
                      data_byte == 8'd0 && !in_program)
    `CPWBD_ASSERT_IMP(a_stall_from_backpressure, clk, rst_n, in_stall,
                      out_valid && out_stall)

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cassette pulse width byte decoder core: a short
// table of directed samples, then whole random tapes (sync marks, names,
// program bytes, partial bytes, noise) under several idle and stall patterns,
// every result checked in order against pinned values or a behavioral decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cpwbd_pkg::*;

    localparam int NAME_MAX       = 30;
    localparam int ITEM_TARGET    = 1400;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 150;

    localparam logic [4:0] ONE_RUN_MIN [8] = '{5'd17, 5'd15, 5'd13, 5'd12,
                                               5'd10, 5'd8, 5'd8, 5'd8};

    typedef enum logic [2:0] {
        SEEK_FIRST_SYNC,
        NAME_BYTES,
        SEEK_PROG_SYNC,
        PROG_BYTES,
        NAME_FAILED
    } decode_stage_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       in_program;
        logic       done;
        status_t    status;
    } decoded_t;

    typedef struct packed {
        logic       is_write;
        cfg_index_t reg_index;
        logic [7:0] value;
        logic       last;
        logic       pinned;
        logic       pinned_has;
        decoded_t   pinned_res;
    } directed_row_t;

    localparam decoded_t NO_RES      = '0;
    localparam decoded_t END_NO_NAME = '{1'b0, 8'h00, 1'b0, 1'b1, STATUS_NO_NAME_SYNC};
    localparam decoded_t END_NO_PROG = '{1'b0, 8'h00, 1'b0, 1'b1, STATUS_NO_PROG_SYNC};

    localparam directed_row_t DIRECTED [19] = '{
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'hFF, 1'b1, 1'b1, 1'b1, END_NO_NAME},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h80, 1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h81, 1'b0, 1'b0, 1'b0, NO_RES},
        // open low run on the last sample is dropped
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h00, 1'b1, 1'b1, 1'b1, END_NO_NAME},
        '{1'b1, CFG_SKIP_NAME,       8'h01, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h7F, 1'b1, 1'b1, 1'b1, END_NO_PROG},
        '{1'b1, CFG_LEVEL_THRESHOLD, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h01, 1'b0, 1'b1, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        // bit completed on the last sample, still hunting
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h01, 1'b1, 1'b1, 1'b1, END_NO_PROG},
        '{1'b1, CFG_LEVEL_THRESHOLD, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h00, 1'b1, 1'b1, 1'b1, END_NO_PROG},
        '{1'b1, CFG_SPEED_SELECT,    8'h07, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_SKIP_NAME,       8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, CFG_LEVEL_THRESHOLD, 8'h55, 1'b1, 1'b1, 1'b1, END_NO_NAME},
        '{1'b1, CFG_SPEED_SELECT,    8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_LEVEL_THRESHOLD, 8'h80, 1'b0, 1'b0, 1'b0, NO_RES}
    };

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] sample      = 8'h00;
    logic       last_sample = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       in_program;
    logic       done_res;
    logic [1:0] status;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_index   = CFG_LEVEL_THRESHOLD;
    logic [7:0] cfg_data    = 8'h00;

    // pinned expectation travels with the request
    logic     row_pinned     = 1'b0;
    logic     row_pinned_has = 1'b0;
    decoded_t row_pinned_res = '0;

    // decoder copy
    logic [7:0]    thr_reg;
    logic [2:0]    speed_reg;
    logic          skip_reg;
    decode_stage_t stage_q;
    logic          low_run_q;
    logic [7:0]    run_len_q;
    logic [7:0]    window_q;
    logic [3:0]    bits_q;
    logic [4:0]    names_q;

    decoded_t   decoded_pending [$];
    logic [7:0] tape_q [$];
    int         failures   = 0;
    int         items_sent = 0;
    int         quiet      = 0;
    int         hold_count = 0;
    logic       hold_done  = 1'b0;

    cassette_pulse_width_byte_decoder_core #(
        .NAME_MAX_BYTES(NAME_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last_sample(last_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .in_program (in_program),
        .done_res   (done_res),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void rearm_decoder();
        stage_q   = SEEK_FIRST_SYNC;
        low_run_q = 1'b0;
        run_len_q = '0;
        window_q  = '0;
        bits_q    = '0;
        names_q   = '0;
    endfunction

    function automatic logic shift_bit(input logic level_bit, output logic [7:0] dbyte,
                                       output logic prog);
        dbyte    = '0;
        prog     = 1'b0;
        window_q = {window_q[6:0], level_bit};
        if (stage_q == SEEK_FIRST_SYNC || stage_q == SEEK_PROG_SYNC)
        begin
            if (window_q == SYNC_MARK)
            begin
                if (stage_q == SEEK_FIRST_SYNC && !skip_reg)
                    stage_q = NAME_BYTES;
                else
                    stage_q = PROG_BYTES;
                window_q = '0;
                bits_q   = '0;
            end
            return 1'b0;
        end
        if (stage_q == NAME_FAILED)
            return 1'b0;
        bits_q = bits_q + 4'd1;
        if (bits_q < 4'd8)
            return 1'b0;
        dbyte    = window_q;
        window_q = '0;
        bits_q   = '0;
        if (stage_q == PROG_BYTES)
        begin
            prog = 1'b1;
            return 1'b1;
        end
        names_q = names_q + 5'd1;
        if (names_q >= NAME_MAX)
            stage_q = NAME_FAILED;
        else if (names_q >= 5'd2 && dbyte == QUOTE_CHAR)
            stage_q = SEEK_PROG_SYNC;
        return 1'b1;
    endfunction

    function automatic logic decode_sample(input logic [7:0] level, input logic last,
                                           output decoded_t res);
        logic       got;
        logic       level_bit;
        logic [7:0] dbyte;
        logic       prog;
        got   = 1'b0;
        dbyte = '0;
        prog  = 1'b0;
        res   = '0;
        if (level <= thr_reg)
        begin
            if (!low_run_q)
            begin
                low_run_q = 1'b1;
                run_len_q = 8'd1;
            end
            else if (run_len_q != 8'hFF)
                run_len_q = run_len_q + 8'd1;
        end
        else if (low_run_q)
        begin
            level_bit = (run_len_q >= ONE_RUN_MIN[speed_reg]);
            low_run_q = 1'b0;
            run_len_q = '0;
            got = shift_bit(level_bit, dbyte, prog);
        end
        if (!got && !last)
            return 1'b0;
        res.byte_valid = got;
        res.data_byte  = dbyte;
        res.in_program = prog;
        res.done       = last;
        res.status     = STATUS_OK;
        if (last)
        begin
            case (stage_q)
                SEEK_FIRST_SYNC:
                    if (skip_reg)
                        res.status = STATUS_NO_PROG_SYNC;
                    else
                        res.status = STATUS_NO_NAME_SYNC;
                NAME_BYTES, NAME_FAILED:
                    res.status = STATUS_BAD_NAME;
                SEEK_PROG_SYNC:
                    res.status = STATUS_NO_PROG_SYNC;
                default:
                    res.status = STATUS_OK;
            endcase
            rearm_decoder();
        end
        return 1'b1;
    endfunction

    function automatic int idle_phase();
        return (items_sent / PHASE_ITEMS) % 4;
    endfunction

    function automatic int sender_gap();
        int g;
        int pct;
        g = 0;
        case (idle_phase())
            1:       pct = 77;
            3:       pct = 17;
            default: pct = 0;
        endcase
        while (g < 60 && $urandom_range(99, 0) < pct)
            g++;
        return g;
    endfunction

    function automatic logic [7:0] low_level();
        case ($urandom_range(7, 0))
            0:       return thr_reg;
            1:       return 8'h00;
            default: return 8'($urandom_range(thr_reg, 0));
        endcase
    endfunction

    function automatic logic [7:0] high_level();
        case ($urandom_range(7, 0))
            0:       return thr_reg + 8'd1;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255, thr_reg + 1));
        endcase
    endfunction

    function automatic void push_bit(input logic level_bit);
        int w;
        int len;
        int highs;
        w = ONE_RUN_MIN[speed_reg];
        if (level_bit)
        begin
            case ($urandom_range(15, 0))
                0:       len = w;
                1:       len = $urandom_range(w + 30, w + 1);
                2:       len = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 250) : w + 1;
                default: len = w + $urandom_range(2, 0);
            endcase
        end
        else
            len = ($urandom_range(9, 0) == 0) ? w - 1 : $urandom_range(2, 1);
        highs = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 2) : 1;
        repeat (len) tape_q.push_back(low_level());
        repeat (highs) tape_q.push_back(high_level());
    endfunction

    function automatic void push_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--)
            push_bit(v[i]);
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == QUOTE_CHAR)
            v = QUOTE_CHAR + 8'd1;
        return v;
    endfunction

    task automatic build_tape(input logic long_name);
        int   kind;
        int   n;
        logic synced;
        logic open_end;
        tape_q.delete();
        kind = long_name ? 99 : $urandom_range(99, 0);
        if (thr_reg == 8'hFF || kind < 10)
        begin
            repeat ($urandom_range(60, 3)) tape_q.push_back(8'($urandom));
            if ($urandom_range(3, 0) == 0)
            begin
                repeat ($urandom_range(300, 250)) tape_q.push_back(8'h00);
                if (thr_reg != 8'hFF)
                    tape_q.push_back(high_level());
            end
        end
        else
        begin
            repeat ($urandom_range(6, 0))
                push_bit(($urandom_range(4, 0) == 0) ? 1'($urandom) : 1'b0);
            synced   = (kind >= 18);
            open_end = 1'b0;
            if (!synced)
            begin
                push_byte(SYNC_MARK ^ (8'h01 << $urandom_range(7, 0)));
                repeat ($urandom_range(3, 0)) push_byte(8'($urandom));
            end
            else
            begin
                push_byte(SYNC_MARK);
                if (!skip_reg)
                begin
                    n = long_name ? NAME_MAX + $urandom_range(2, 0) : $urandom_range(5, 1);
                    for (int i = 0; i < n; i++)
                    begin
                        if (i == 0 && $urandom_range(3, 0) == 0)
                            push_byte(QUOTE_CHAR);
                        else
                            push_byte(long_name ? (name_char() & 8'h01) : name_char());
                    end
                    if (long_name || $urandom_range(7, 0) == 0)
                        open_end = 1'b1;
                    else
                    begin
                        push_byte(QUOTE_CHAR);
                        repeat ($urandom_range(4, 0)) push_bit(1'b0);
                        if ($urandom_range(6, 0) == 0)
                        begin
                            push_byte(name_char());
                            open_end = 1'b1;
                        end
                        else
                            push_byte(SYNC_MARK);
                    end
                end
                if (!open_end)
                begin
                    repeat ($urandom_range(6, 0)) push_byte(8'($urandom));
                    if ($urandom_range(2, 0) == 0)
                        repeat ($urandom_range(7, 1)) push_bit(1'($urandom));
                end
            end
        end
        case ($urandom_range(3, 0))
            0, 1:
                while (tape_q.size() > 1 && tape_q[tape_q.size() - 2] > thr_reg)
                    void'(tape_q.pop_back());
            2:
                tape_q.push_back(low_level());
            default:
                ;
        endcase
    endtask

    task automatic offer_sample(input logic [7:0] level, input logic last, input logic pinned,
                                input logic pinned_has, input decoded_t pinned_res);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= level;
        last_sample    <= last;
        row_pinned     <= pinned;
        row_pinned_has <= pinned_has;
        row_pinned_res <= pinned_res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic play_tape();
        for (int i = 0; i < tape_q.size(); i++)
            offer_sample(tape_q[i], i == tape_q.size() - 1, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LEVEL_THRESHOLD: thr_reg = value;
            CFG_SPEED_SELECT:    speed_reg = value[2:0];
            default:             skip_reg = value[0];
        endcase
    endtask

    task automatic pick_settings(input logic force_name);
        logic [7:0] t;
        if (force_name)
        begin
            write_reg(CFG_LEVEL_THRESHOLD, 8'd100);
            write_reg(CFG_SPEED_SELECT, 8'd7);
            write_reg(CFG_SKIP_NAME, 8'd0);
        end
        else
        begin
            if ($urandom_range(1, 0) == 0)
            begin
                case ($urandom_range(9, 0))
                    0:       t = 8'h00;
                    1:       t = 8'hFF;
                    2:       t = 8'hFE;
                    default: t = 8'($urandom_range(200, 40));
                endcase
                write_reg(CFG_LEVEL_THRESHOLD, t);
            end
            if ($urandom_range(1, 0) == 0)
                write_reg(CFG_SPEED_SELECT, ($urandom_range(3, 0) == 0) ?
                          8'($urandom_range(7, 0)) : 8'($urandom_range(7, 4)));
            if ($urandom_range(2, 0) == 0)
                write_reg(CFG_SKIP_NAME, 8'($urandom_range(3, 0) == 0));
        end
    endtask

    // predict every accepted request
    always @(posedge clk)
    begin : take_request
        decoded_t r;
        logic     has;
        if (rst_n && in_valid && !in_stall)
        begin
            has = decode_sample(sample, last_sample, r);
            if (row_pinned)
            begin
                if (row_pinned_has)
                    decoded_pending.push_back(row_pinned_res);
            end
            else if (has)
                decoded_pending.push_back(r);
        end
    end

    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_pending.size() == 0)
            begin
                $error("result with nothing expected: data_byte %02h done_res %0b",
                       data_byte, done_res);
                failures++;
            end
            else
            begin
                want = decoded_pending.pop_front();
                if (byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
                    failures++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %02h, got %02h", want.data_byte, data_byte);
                    failures++;
                end
                if (in_program !== want.in_program)
                begin
                    $error("in_program: expected %0b, got %0b", want.in_program, in_program);
                    failures++;
                end
                if (done_res !== want.done)
                begin
                    $error("done_res: expected %0b, got %0b", want.done, done_res);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
            end
        end
    end

    // receiver: random stalls per phase, one long hold to back up the input
    always @(posedge clk)
    begin
        if (hold_count > 0)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count - 1;
        end
        else if (!hold_done && items_sent >= HOLD_AT)
        begin
            hold_done  <= 1'b1;
            hold_count <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
        begin
            case (idle_phase())
                2:       out_stall <= ($urandom_range(99, 0) < 77);
                3:       out_stall <= ($urandom_range(99, 0) < 17);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin : stimulus
        directed_row_t row;
        int            tape_count;
        logic          long_done;
        logic          long_due;
        thr_reg    = 8'd128;
        speed_reg  = 3'd0;
        skip_reg   = 1'b0;
        tape_count = 0;
        long_done  = 1'b0;
        rearm_decoder();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.is_write)
                write_reg(row.reg_index, row.value);
            else
                offer_sample(row.value, row.last, row.pinned, row.pinned_has, row.pinned_res);
        end

        while (items_sent < ITEM_TARGET || !long_done)
        begin
            long_due = !long_done;
            if (long_due || tape_count == 0 || $urandom_range(2, 0) == 0)
                pick_settings(long_due);
            build_tape(long_due);
            play_tape();
            if (long_due)
                long_done = 1'b1;
            tape_count++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/cpwbd_pkg.sv
src/cpwbd_bit_slicer.sv
src/cpwbd_byte_framer.sv
src/cassette_pulse_width_byte_decoder_core.sv
bench/tb.sv
